[rtl/bps_pkg.sv]
// Shared types and codes for the byte and pair scanner.
`default_nettype none

package bps_pkg;

    localparam int POS_W = 17;

    // scan modes
    localparam logic [2:0] MODE_FIRST_EQ    = 3'd0;
    localparam logic [2:0] MODE_FIRST_NE    = 3'd1;
    localparam logic [2:0] MODE_LAST_EQ     = 3'd2;
    localparam logic [2:0] MODE_LAST_NE     = 3'd3;
    localparam logic [2:0] MODE_FIRST_PAIR  = 3'd4;
    localparam logic [2:0] MODE_LAST_PAIR   = 3'd5;
    localparam logic [2:0] MODE_MASKED_PAIR = 3'd6;
    localparam logic [2:0] MODE_UNUSED      = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_SCAN_MODE     = 3'd0;
    localparam logic [2:0] REG_FIRST_TARGET  = 3'd1;
    localparam logic [2:0] REG_SECOND_TARGET = 3'd2;
    localparam logic [2:0] REG_FIRST_MASK    = 3'd3;
    localparam logic [2:0] REG_SECOND_MASK   = 3'd4;
    localparam logic [2:0] REG_IGNORE_CASE   = 3'd5;

    localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } scan_in_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] position;
    } scan_out_t;

endpackage

`default_nettype wire

[rtl/byte_and_pair_scanner_top.sv]
// Top level of the byte and pair scanner.
//
// Usage:
//   data channel (data_valid/data_ready/data_item) takes one buffer byte per
//   item; end_of_buffer marks the final byte of a buffer.
//   result channel (result_valid/result_ready/result_item) gives one item per
//   buffer, after its final byte: hit and position.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the mode,
//   targets, masks and case folding; cfg_ready is always high. Write it only
//   while no buffer is in flight.
// Timing:
//   one byte per cycle while no final byte waits on a stalled result; each
//   byte passes an input register, and its compare and flag update run from
//   that register against the search state. The result is written to the
//   output register when the final byte leaves the input register.
// Stall: while a result waits, non-final bytes keep flowing; a second final
//   byte waits in the input register until the pending result is taken.
// Reset: rst_n clears the search state, both valid flags and the
//   configuration registers to their reset values (masks 0xFF, all others 0).
`default_nettype none

module byte_and_pair_scanner_top #(
    parameter int MAX_LENGTH = 65536
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 data_valid,
    output logic                data_ready,
    input  wire bps_pkg::scan_in_t data_item,
    output logic                result_valid,
    input  wire                 result_ready,
    output bps_pkg::scan_out_t  result_item,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [7:0]          cfg_data
);

    localparam int OFS_W  = $clog2(MAX_LENGTH + 1);
    localparam int WIDE_W = (OFS_W > bps_pkg::POS_W) ? OFS_W : bps_pkg::POS_W;
    localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_LENGTH);
    localparam logic [OFS_W-1:0] ONE_OFS = OFS_W'(1);

    // configuration registers
    logic [2:0] scan_mode_reg;
    logic [7:0] first_target_reg;
    logic [7:0] second_target_reg;
    logic [7:0] first_mask_reg;
    logic [7:0] second_mask_reg;
    logic       ignore_case_reg;

    // input stage
    logic               s1_valid_reg, s1_valid_next;
    bps_pkg::scan_in_t  s1_item_reg;

    // search state
    logic [OFS_W-1:0] offset_reg, offset_next;
    logic             prev_first_reg, prev_first_next;
    logic             seen_reg, seen_next;
    logic [OFS_W-1:0] match_ofs_reg, match_ofs_next;

    // output stage
    logic               out_valid_reg, out_valid_next;
    bps_pkg::scan_out_t out_item_reg, out_item_next;

    logic             s1_advance;
    logic [2:0]       mode;
    logic [7:0]       fold_mask;
    logic [7:0]       first_masked, second_masked;
    logic             is_first, is_second, pair;
    logic             forward;
    logic [OFS_W-1:0] length;
    logic [OFS_W-1:0] pos;
    logic             hit;
    logic [WIDE_W-1:0] pos_wide;

    assign cfg_ready    = 1'b1;
    assign s1_advance   = s1_valid_reg
                          && (!s1_item_reg.end_of_buffer || !out_valid_reg || result_ready);
    assign data_ready   = !s1_valid_reg || s1_advance;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg     <= bps_pkg::MODE_FIRST_EQ;
            first_target_reg  <= 8'h00;
            second_target_reg <= 8'h00;
            first_mask_reg    <= 8'hFF;
            second_mask_reg   <= 8'hFF;
            ignore_case_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bps_pkg::REG_SCAN_MODE:     scan_mode_reg     <= cfg_data[2:0];
                bps_pkg::REG_FIRST_TARGET:  first_target_reg  <= cfg_data;
                bps_pkg::REG_SECOND_TARGET: second_target_reg <= cfg_data;
                bps_pkg::REG_FIRST_MASK:    first_mask_reg    <= cfg_data;
                bps_pkg::REG_SECOND_MASK:   second_mask_reg   <= cfg_data;
                bps_pkg::REG_IGNORE_CASE:   ignore_case_reg   <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        mode      = (scan_mode_reg == bps_pkg::MODE_UNUSED) ? bps_pkg::MODE_FIRST_EQ
                                                             : scan_mode_reg;
        fold_mask = ignore_case_reg ? bps_pkg::CASE_FOLD_MASK : 8'hFF;
        if (mode == bps_pkg::MODE_MASKED_PAIR)
        begin
            first_masked  = s1_item_reg.data_byte & first_mask_reg;
            second_masked = s1_item_reg.data_byte & second_mask_reg;
        end
        else
        begin
            first_masked  = s1_item_reg.data_byte & fold_mask;
            second_masked = s1_item_reg.data_byte & fold_mask;
        end
        is_first  = (first_masked == first_target_reg);
        is_second = (second_masked == second_target_reg);
        pair      = prev_first_reg && is_second;

        seen_next      = seen_reg;
        match_ofs_next = match_ofs_reg;
        case (mode)
            bps_pkg::MODE_FIRST_EQ, bps_pkg::MODE_FIRST_NE:
            begin
                if (!seen_reg && ((mode == bps_pkg::MODE_FIRST_EQ) ? is_first : !is_first))
                begin
                    seen_next      = 1'b1;
                    match_ofs_next = offset_reg;
                end
            end
            bps_pkg::MODE_LAST_EQ, bps_pkg::MODE_LAST_NE:
            begin
                if ((mode == bps_pkg::MODE_LAST_EQ) ? is_first : !is_first)
                begin
                    seen_next      = 1'b1;
                    match_ofs_next = offset_reg;
                end
            end
            bps_pkg::MODE_FIRST_PAIR, bps_pkg::MODE_MASKED_PAIR:
            begin
                // report the first byte of the pair; a saturated offset stays put
                if (!seen_reg && pair)
                begin
                    seen_next      = 1'b1;
                    match_ofs_next = (offset_reg < MAX_OFS) ? offset_reg - ONE_OFS : MAX_OFS;
                end
            end
            default:
            begin
                if (pair)
                begin
                    seen_next      = 1'b1;
                    match_ofs_next = offset_reg;
                end
            end
        endcase
        prev_first_next = is_first;
        offset_next     = (offset_reg < MAX_OFS) ? offset_reg + ONE_OFS : MAX_OFS;

        // final-byte result
        length  = (offset_reg < MAX_OFS) ? offset_reg + ONE_OFS : MAX_OFS;
        forward = (mode == bps_pkg::MODE_FIRST_EQ) || (mode == bps_pkg::MODE_FIRST_NE)
                  || (mode == bps_pkg::MODE_FIRST_PAIR) || (mode == bps_pkg::MODE_MASKED_PAIR);
        if (seen_next)
        begin
            hit = 1'b1;
            pos = match_ofs_next;
        end
        else if (((mode == bps_pkg::MODE_FIRST_PAIR) || (mode == bps_pkg::MODE_MASKED_PAIR))
                 && is_first)
        begin
            hit = 1'b1;
            pos = offset_reg;
        end
        else
        begin
            hit = 1'b0;
            pos = forward ? length : '0;
        end
        pos_wide               = WIDE_W'(pos);
        out_item_next.hit      = hit;
        out_item_next.position = pos_wide[bps_pkg::POS_W-1:0];

        s1_valid_next  = data_ready ? data_valid : s1_valid_reg;
        out_valid_next = (s1_advance && s1_item_reg.end_of_buffer) ? 1'b1
                         : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            offset_reg     <= '0;
            prev_first_reg <= 1'b0;
            seen_reg       <= 1'b0;
            match_ofs_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                if (s1_item_reg.end_of_buffer)
                begin
                    // clear the search for the next buffer
                    offset_reg     <= '0;
                    prev_first_reg <= 1'b0;
                    seen_reg       <= 1'b0;
                    match_ofs_reg  <= '0;
                end
                else
                begin
                    offset_reg     <= offset_next;
                    prev_first_reg <= prev_first_next;
                    seen_reg       <= seen_next;
                    match_ofs_reg  <= match_ofs_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            s1_item_reg <= data_item;
        end
        if (s1_advance && s1_item_reg.end_of_buffer)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bps_checker.sv]
// Port-level checks for the byte and pair scanner, bound to its top level.
`default_nettype none

module bps_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 data_valid,
    input wire                 data_ready,
    input wire bps_pkg::scan_in_t  data_item,
    input wire                 result_valid,
    input wire                 result_ready,
    input wire bps_pkg::scan_out_t result_item
);

    // final bytes accepted whose result is not yet taken
    logic [1:0] pending_reg, pending_next;
    logic       end_in, result_out;

    assign end_in     = data_valid && data_ready && data_item.end_of_buffer;
    assign result_out = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, end_in} - {1'b0, result_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("stalled result item changed or dropped");

    assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid after a reset edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result item without an accepted final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 && !result_ready |-> !data_ready)
        else $error("byte accepted while two buffers are pending and output stalls");

endmodule

bind byte_and_pair_scanner_top bps_checker u_bps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_item    (data_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

`default_nettype wire
